FILE: rtl/min_max_queue_range_defines.svh
// Assertion macros of the min/max queue checker.
`ifndef MIN_MAX_QUEUE_RANGE_DEFINES_SVH
`define MIN_MAX_QUEUE_RANGE_DEFINES_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define MMQR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when ante holds, cons must hold in the same cycle.
`define MMQR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication form: when ante holds, cons must hold in the next cycle.
`define MMQR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mmqr_pkg.sv
// Shared constants and types of the min/max queue with range query.
`timescale 1ns / 1ps
package mmqr_pkg;

  localparam int unsigned DefDepth = 1024;
  localparam int unsigned ValW     = 32;

  // Operation codes on kind
  localparam logic [1:0] KindPush  = 2'd0;
  localparam logic [1:0] KindPop   = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;

  // Result status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MV_RD,
    S_MV_WR,
    S_Q_WAIT
  } state_e;

endpackage

FILE: rtl/mmqr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mmqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/min_max_queue_range.sv
// Push, pop from a filled output stack, and a query answered from the input stack: result next cycle.
// A query that reads the output stack top waits in S_Q_WAIT for the registered RAM read data.
// A pop that finds the output stack empty moves all N input entries across, each by a RAM
// read in S_MV_RD, then a RAM write in S_MV_WR; the last entry moved is the one popped.
// A new beat is taken while the previous result is being taken on the output side.
// Reset clears state, counts, input stack extremes and the result register; the stack RAMs keep their contents.
`timescale 1ns / 1ps
module min_max_queue_range #(
  parameter int unsigned DEPTH = mmqr_pkg::DefDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic signed [mmqr_pkg::ValW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [mmqr_pkg::ValW-1:0]        range_o
);
  import mmqr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [ValW-1:0] span(logic signed [ValW-1:0] hi,
                                           logic signed [ValW-1:0] lo);
    logic signed [ValW:0] d;
    d = {hi[ValW-1], hi} - {lo[ValW-1], lo};
    return d[ValW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [CW-1:0] in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
  logic [CW-1:0] in_top_idx, out_top_idx;
  logic [CW:0]   total;
  logic          full, two_held;

  logic signed [ValW-1:0] in_max_q, in_max_d, in_min_q, in_min_d;
  logic signed [ValW-1:0] mv_hi_q, mv_hi_d, mv_lo_q, mv_lo_d;
  logic signed [ValW-1:0] push_max, push_min, mv_x, mv_hi, mv_lo, q_hi, q_lo;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      status_q, status_d;
  logic [ValW-1:0] range_q, range_d;

  logic                 in_we;
  logic [AW-1:0]        in_waddr, in_raddr;
  logic [ValW-1:0]      in_rdata;
  logic                 out_we;
  logic [AW-1:0]        out_waddr;
  logic [2*ValW-1:0]    out_wdata, out_rdata;

  mmqr_ram #(.WIDTH(ValW), .DEPTH(DEPTH)) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (in_waddr),
    .wdata_i (value_i),
    .raddr_i (in_raddr),
    .rdata_o (in_rdata)
  );

  mmqr_ram #(.WIDTH(2 * ValW), .DEPTH(DEPTH)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (out_waddr),
    .wdata_i (out_wdata),
    .raddr_i (out_top_idx[AW-1:0]),
    .rdata_o (out_rdata)
  );

  assign in_top_idx  = in_cnt_q - CW'(1);
  assign out_top_idx = out_cnt_q - CW'(1);
  assign total       = {1'b0, in_cnt_q} + {1'b0, out_cnt_q};
  assign full        = total >= (CW + 1)'(DEPTH);
  assign two_held    = total >= (CW + 1)'(2);

  assign in_waddr  = in_cnt_q[AW-1:0];
  assign in_raddr  = in_top_idx[AW-1:0];
  assign out_waddr = out_cnt_q[AW-1:0];
  assign out_wdata = {mv_hi, mv_lo};

  // Running extremes of the input stack after a push
  always_comb begin
    push_max = in_max_q;
    push_min = in_min_q;
    if (in_cnt_q == '0) begin
      push_max = value_i;
      push_min = value_i;
    end else begin
      if (value_i > in_max_q) push_max = value_i;
      if (value_i < in_min_q) push_min = value_i;
    end
  end

  // Running extremes of the output stack while moving entries across
  always_comb begin
    mv_x  = in_rdata;
    mv_hi = mv_hi_q;
    mv_lo = mv_lo_q;
    if (out_cnt_q == '0) begin
      mv_hi = mv_x;
      mv_lo = mv_x;
    end else begin
      if (mv_x > mv_hi_q) mv_hi = mv_x;
      if (mv_x < mv_lo_q) mv_lo = mv_x;
    end
  end

  // Merge the output stack top with the input stack extremes
  always_comb begin
    q_hi = out_rdata[2*ValW-1:ValW];
    q_lo = out_rdata[ValW-1:0];
    if (in_cnt_q != '0) begin
      if (in_max_q > q_hi) q_hi = in_max_q;
      if (in_min_q < q_lo) q_lo = in_min_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_cnt_d    = in_cnt_q;
    out_cnt_d   = out_cnt_q;
    in_max_d    = in_max_q;
    in_min_d    = in_min_q;
    mv_hi_d     = mv_hi_q;
    mv_lo_d     = mv_lo_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    range_d     = range_q;
    in_we       = 1'b0;
    out_we      = 1'b0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          status_d = StOk;
          range_d  = '0;
          unique case (kind_i)
            KindPush: begin
              out_valid_d = 1'b1;
              if (full) begin
                status_d = StFull;
              end else begin
                in_we    = 1'b1;
                in_cnt_d = in_cnt_q + CW'(1);
                in_max_d = push_max;
                in_min_d = push_min;
              end
            end
            KindPop: begin
              if (out_cnt_q != '0) begin
                out_cnt_d   = out_top_idx;
                out_valid_d = 1'b1;
              end else if (in_cnt_q == '0) begin
                status_d    = StEmpty;
                out_valid_d = 1'b1;
              end else begin
                state_d = S_MV_RD;
              end
            end
            KindQuery: begin
              if (!two_held) begin
                out_valid_d = 1'b1;
              end else if (out_cnt_q == '0) begin
                range_d     = span(in_max_q, in_min_q);
                out_valid_d = 1'b1;
              end else begin
                // output stack top is being read this cycle
                state_d = S_Q_WAIT;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_MV_RD: begin
        // read of the input stack top issued here
        in_cnt_d = in_top_idx;
        state_d  = S_MV_WR;
      end
      S_MV_WR: begin
        out_we  = 1'b1;
        mv_hi_d = mv_hi;
        mv_lo_d = mv_lo;
        if (in_cnt_q == '0) begin
          // last entry moved: the pop takes it right back off, count holds
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          out_cnt_d = out_cnt_q + CW'(1);
          state_d   = S_MV_RD;
        end
      end
      S_Q_WAIT: begin
        range_d     = span(q_hi, q_lo);
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      in_max_q    <= '0;
      in_min_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StOk;
      range_q     <= '0;
    end else begin
      state_q     <= state_d;
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      in_max_q    <= in_max_d;
      in_min_q    <= in_min_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      range_q     <= range_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_hi_q <= mv_hi_d;
    mv_lo_q <= mv_lo_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign range_o     = range_q;

endmodule

FILE: rtl/mmqr_checker.sv
// Port-level checker of the min/max queue, bound to the top level.
`timescale 1ns / 1ps
`include "min_max_queue_range_defines.svh"
module mmqr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [1:0]                  kind_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic [mmqr_pkg::ValW-1:0]   range_o
);
  import mmqr_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;
  logic [1:0] kind_q;

  assign in_acc = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign pend_d = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      kind_q <= KindPush;
    end else begin
      pend_q <= pend_d;
      if (in_acc) begin
        kind_q <= kind_i;
      end
    end
  end

  `MMQR_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(range_o), "result beat changed while stalled")
  `MMQR_ASSERT_IMP(a_no_orphan, out_valid_o, pend_q != 2'd0, "result beat without an accepted item")
  `MMQR_ASSERT(a_one_in_flight, pend_q[1] == 1'b0, "more than one item outstanding")
  `MMQR_ASSERT_IMP(a_full_on_push, out_valid_o && status_o == StFull, kind_q == KindPush, "full status for a non-push item")
  `MMQR_ASSERT_IMP(a_err_no_range, out_valid_o && status_o != StOk, range_o == '0, "error status with nonzero range")

endmodule

bind min_max_queue_range mmqr_checker u_mmqr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .range_o     (range_o)
);

FILE: sim/tb_min_max_queue_range.sv
// Self-checking testbench for the min/max queue with range query.
`timescale 1ns / 1ps
module tb_min_max_queue_range;
  import mmqr_pkg::*;

  localparam int unsigned Depth = DefDepth;
  localparam logic [1:0] KindSpare = 2'd3;
  localparam int MaxShown = 10;
  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]      status;
    logic [ValW-1:0] span;
  } result_t;

  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_e;

  class range_scoreboard;
    logic signed [ValW-1:0] in_stack [Depth];
    logic signed [ValW-1:0] out_hi [Depth];
    logic signed [ValW-1:0] out_lo [Depth];
    int unsigned in_cnt;
    int unsigned out_cnt;
    logic signed [ValW-1:0] in_hi;
    logic signed [ValW-1:0] in_lo;
    result_t expected_q[$];
    int mismatches;

    function new();
      in_cnt = 0;
      out_cnt = 0;
      in_hi = '0;
      in_lo = '0;
      mismatches = 0;
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= MaxShown) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the queue state by one accepted input beat and queue its result.
    function void note_beat(logic [1:0] kind, logic signed [ValW-1:0] value);
      result_t r;
      logic signed [ValW-1:0] x;
      logic signed [ValW-1:0] hi;
      logic signed [ValW-1:0] lo;
      r.status = StOk;
      r.span = '0;
      hi = '0;
      lo = '0;
      case (kind)
        KindPush: begin
          if (in_cnt + out_cnt >= Depth) begin
            r.status = StFull;
          end else begin
            if (in_cnt == 0) begin
              in_hi = value;
              in_lo = value;
            end else begin
              if (value > in_hi) in_hi = value;
              if (value < in_lo) in_lo = value;
            end
            in_stack[in_cnt] = value;
            in_cnt++;
          end
        end
        KindPop: begin
          if (in_cnt == 0 && out_cnt == 0) begin
            r.status = StEmpty;
          end else begin
            // Refill the output stack newest first, keeping running extremes.
            if (out_cnt == 0) begin
              while (in_cnt > 0) begin
                in_cnt--;
                x = in_stack[in_cnt];
                if (out_cnt == 0) begin
                  hi = x;
                  lo = x;
                end else begin
                  if (x > hi) hi = x;
                  if (x < lo) lo = x;
                end
                out_hi[out_cnt] = hi;
                out_lo[out_cnt] = lo;
                out_cnt++;
              end
            end
            out_cnt--;
          end
        end
        KindQuery: begin
          if (in_cnt + out_cnt >= 2) begin
            if (out_cnt == 0) begin
              hi = in_hi;
              lo = in_lo;
            end else begin
              hi = out_hi[out_cnt-1];
              lo = out_lo[out_cnt-1];
              if (in_cnt > 0) begin
                if (in_hi > hi) hi = in_hi;
                if (in_lo < lo) lo = in_lo;
              end
            end
            r.span = hi - lo;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [ValW-1:0] span);
      result_t e;
      if (expected_q.size() == 0) begin
        note_error($sformatf("unexpected result: status %0d range %h", status, span));
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status)
        note_error($sformatf("status: expected %0d, got %0d", e.status, status));
      if (span !== e.span)
        note_error($sformatf("range: expected %h, got %h", e.span, span));
    endfunction

    function void close_out();
      result_t e;
      while (expected_q.size() > 0) begin
        e = expected_q.pop_front();
        note_error($sformatf("missing result: status %0d range %h", e.status, e.span));
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic [1:0]             kind_i = KindPush;
  logic signed [ValW-1:0] value_i = '0;
  logic                   out_ready_i = 1'b0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [1:0]             status_o;
  logic [ValW-1:0]        range_o;

  idle_e           idle_mode = IdleNone;
  int unsigned     held = 0;
  int unsigned     sent = 0;
  range_scoreboard sb;

  min_max_queue_range #(
    .DEPTH(Depth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .range_o    (range_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= (idle_mode == IdleRecv) ? ($urandom_range(99) >= 47) :
                   (idle_mode == IdleBoth) ? ($urandom_range(99) >= 24) : 1'b1;
  end

  // Check the result beat before noting the input beat taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(status_o, range_o);
      if (in_valid_i && in_ready_o) sb.note_beat(kind_i, value_i);
    end
  end

  task automatic send_beat(input logic [1:0] kind, input logic signed [ValW-1:0] value);
    int unsigned pct;
    pct = (idle_mode == IdleSend) ? 47 : (idle_mode == IdleBoth) ? 24 : 0;
    if (pct != 0 && $urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    case (kind)
      KindPush: if (held < Depth) held++;
      KindPop:  if (held > 0) held--;
      default: ;
    endcase
    sent++;
    idle_mode = idle_e'((sent / 120) % 4);
  endtask

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(3))
          0: return ValMax;
          1: return ValMin;
          2: return '0;
          default: return '1;
        endcase
      end
      2, 3: return ValW'(int'($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_kind(int unsigned push_pct, int unsigned pop_pct,
                                           int unsigned spare_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return KindPush;
    if (r < push_pct + pop_pct) return KindPop;
    if (r < 100 - spare_pct) return KindQuery;
    return KindSpare;
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, unused kind, single value, full-width extremes.
    send_beat(KindQuery, $urandom);
    send_beat(KindPop, $urandom);
    send_beat(KindSpare, $urandom);
    send_beat(KindPush, ValMax);
    send_beat(KindQuery, $urandom);
    send_beat(KindPush, ValMin);
    send_beat(KindQuery, $urandom);
    send_beat(KindPop, $urandom);
    send_beat(KindQuery, $urandom);
    send_beat(KindPush, '1);
    send_beat(KindQuery, $urandom);
    send_beat(KindPush, 32'sd5);
    send_beat(KindPush, -32'sd7);
    send_beat(KindQuery, $urandom);
    send_beat(KindPop, $urandom);
    send_beat(KindPop, $urandom);
    send_beat(KindQuery, $urandom);
    send_beat(KindPop, $urandom);
    send_beat(KindPop, $urandom);
    send_beat(KindPop, $urandom);
    send_beat(KindQuery, $urandom);

    // Hold off until the block has drained.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);

    // Shallow occupancy: frequent refills of short stacks and empty pops.
    repeat (500) begin
      if (held > 24) send_beat(pick_kind(25, 50, 5), pick_value());
      else send_beat(pick_kind(45, 30, 5), pick_value());
    end
    // Fill to the bound, then push against it.
    while (held < Depth) send_beat(pick_kind(85, 5, 2), pick_value());
    repeat (12) send_beat(pick_kind(60, 0, 0), pick_value());
    // Churn near full, including one long refill of the output stack.
    repeat (120) send_beat(pick_kind(35, 45, 3), pick_value());

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (int n = 0; sb.pending() != 0 && n < 50000; n++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("min_max_queue_range test passed");
    end else begin
      $display("min_max_queue_range test failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("min_max_queue_range test failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mmqr_pkg.sv
rtl/mmqr_ram.sv
rtl/min_max_queue_range.sv
rtl/mmqr_checker.sv
sim/tb_min_max_queue_range.sv
